// ===== rtl/timed_fault_injection_queue_core_defines.svh =====
// assertion macros for the timed fault injection queue
`ifndef TIMED_FAULT_INJECTION_QUEUE_CORE_DEFINES_SVH
`define TIMED_FAULT_INJECTION_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTH
// checked on every edge out of reset
`define TFIQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every edge, reset included
`define TFIQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TFIQ_ASSERT(lbl, prop, msg)
`define TFIQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/tfiq_pkg.sv =====
package tfiq_pkg;

  localparam int DefaultDepth   = 16;
  localparam int DefaultRegBits = 8;

  localparam int TimeW    = 64;
  localparam int IdW      = 32;
  localparam int RegPortW = 8;
  localparam int MaskW    = 64;

  localparam int InDataW  = 296;
  localparam int OutDataW = 240;

  // input tdata field offsets
  localparam int OffTime = 0;
  localparam int OffId   = 64;
  localparam int OffReg  = 96;
  localparam int OffXor  = 104;
  localparam int OffAnd  = 168;
  localparam int OffOr   = 232;

  localparam logic ReqAdd  = 1'b0;
  localparam logic ReqTick = 1'b1;

  localparam logic KindStatus = 1'b0;
  localparam logic KindInject = 1'b1;

  typedef struct packed {
    logic load;
    logic add_start;
    logic add_rd;
    logic add_shift;
    logic add_place;
    logic out_status;
    logic tk_rd;
    logic tk_take;
    logic tk_emit;
    logic emit_last;
    logic tk_stop;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic pos_zero;
    logic rd_gt;
    logic rd_due;
    logic due;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/tfiq_ram.sv =====
module tfiq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/tfiq_ctrl.sv =====
`include "timed_fault_injection_queue_core_defines.svh"

module tfiq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  logic          s_req_i,
  output logic          s_ready_o,
  input  tfiq_pkg::sts_t sts_i,
  output tfiq_pkg::cmd_t cmd_o
);
  import tfiq_pkg::*;

  localparam logic [3:0] IDLE     = 4'd0;
  localparam logic [3:0] ADD_GO   = 4'd1;
  localparam logic [3:0] ADD_TEST = 4'd2;
  localparam logic [3:0] ADD_CHK  = 4'd3;
  localparam logic [3:0] ADD_OUT  = 4'd4;
  localparam logic [3:0] TK_GO    = 4'd5;
  localparam logic [3:0] TK_FIRST = 4'd6;
  localparam logic [3:0] TK_RD    = 4'd7;
  localparam logic [3:0] TK_CHK   = 4'd8;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_ready_o = (state_q == IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (s_req_i == ReqTick) ? TK_GO : ADD_GO;
        end
      end
      ADD_GO: begin
        if (sts_i.full) begin
          state_d = ADD_OUT;
        end else begin
          cmd_o.add_start = 1'b1;
          state_d         = ADD_TEST;
        end
      end
      ADD_TEST: begin
        if (sts_i.pos_zero) begin
          cmd_o.add_place = 1'b1;
          state_d         = ADD_OUT;
        end else begin
          cmd_o.add_rd = 1'b1;
          state_d      = ADD_CHK;
        end
      end
      ADD_CHK: begin
        if (sts_i.rd_gt) begin
          cmd_o.add_shift = 1'b1;
          state_d         = ADD_TEST;
        end else begin
          cmd_o.add_place = 1'b1;
          state_d         = ADD_OUT;
        end
      end
      ADD_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_status = 1'b1;
          state_d          = IDLE;
        end
      end
      TK_GO: begin
        if (sts_i.due) begin
          cmd_o.tk_rd = 1'b1;
          state_d     = TK_FIRST;
        end else begin
          state_d = IDLE;
        end
      end
      TK_FIRST: begin
        cmd_o.tk_take = 1'b1;
        state_d       = TK_RD;
      end
      TK_RD: begin
        cmd_o.tk_rd = 1'b1;
        state_d     = TK_CHK;
      end
      TK_CHK: begin
        if (sts_i.out_free) begin
          cmd_o.tk_emit   = 1'b1;
          cmd_o.emit_last = !sts_i.rd_due;
          if (sts_i.rd_due) begin
            cmd_o.tk_take = 1'b1;
            state_d       = TK_RD;
          end else begin
            cmd_o.tk_stop = 1'b1;
            state_d       = IDLE;
          end
        end
      end
      default: begin
        state_d = IDLE;
      end
    endcase
  end

  `TFIQ_ASSERT(a_take_only_due, cmd_o.tk_take |-> sts_i.rd_due, "fault taken before due")
  `TFIQ_ASSERT(a_out_only_free, (cmd_o.out_status || cmd_o.tk_emit) |-> sts_i.out_free, "output overwritten")
  `TFIQ_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> state_q == IDLE, "not idle in reset")

endmodule

// ===== rtl/tfiq_dpath.sv =====
`include "timed_fault_injection_queue_core_defines.svh"

module tfiq_dpath #(
  parameter int QUEUE_DEPTH    = tfiq_pkg::DefaultDepth,
  parameter int REG_INDEX_BITS = tfiq_pkg::DefaultRegBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [tfiq_pkg::InDataW-1:0]  s_data_i,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [tfiq_pkg::OutDataW-1:0] m_data_o,
  output logic                          m_kind_o,
  output logic                          m_last_o,
  input  tfiq_pkg::cmd_t                cmd_i,
  output tfiq_pkg::sts_t                sts_o
);
  import tfiq_pkg::*;

  localparam int AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int RegW = (REG_INDEX_BITS < RegPortW) ? REG_INDEX_BITS : RegPortW;
  localparam int EW   = TimeW + IdW + RegW + 3 * MaskW;
  localparam int EOffId  = TimeW;
  localparam int EOffReg = TimeW + IdW;
  localparam int EOffXor = TimeW + IdW + RegW;
  localparam int EOffAnd = EOffXor + MaskW;
  localparam int EOffOr  = EOffAnd + MaskW;
  localparam logic [AW:0]   DepthA = (AW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LastA  = AW'(QUEUE_DEPTH - 1);

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DepthA) begin
      s = s - DepthA;
    end
    return s[AW-1:0];
  endfunction

  logic [TimeW-1:0] it_time_q;
  logic [EW-1:0]    it_word_q;
  logic             drop_q;
  logic [AW-1:0]    head_q;
  logic [CW-1:0]    count_q;
  logic [CW-1:0]    pos_q;
  logic [TimeW-1:0] next_due_q;
  logic [EW-1:0]    pend_q;
  logic             m_valid_q;
  logic [OutDataW-1:0] m_data_q;
  logic             m_kind_q;
  logic             m_last_q;

  logic [CW-1:0]    pos_m1;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic             wr_en, rd_en;
  logic [EW-1:0]    wr_data, rd_data;
  logic [TimeW-1:0] rd_time;
  logic             out_free;

  assign pos_m1  = pos_q - 1'b1;
  assign rd_time = rd_data[TimeW-1:0];
  assign out_free = !m_valid_q || m_ready_i;

  assign rd_en   = cmd_i.add_rd || cmd_i.tk_rd;
  assign rd_addr = cmd_i.add_rd ? wrap_add(head_q, pos_m1[AW-1:0]) : head_q;
  assign wr_en   = cmd_i.add_shift || cmd_i.add_place;
  assign wr_addr = wrap_add(head_q, pos_q[AW-1:0]);
  assign wr_data = cmd_i.add_shift ? rd_data : it_word_q;

  tfiq_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      it_time_q <= s_data_i[OffTime +: TimeW];
      it_word_q <= {s_data_i[OffOr +: MaskW], s_data_i[OffAnd +: MaskW],
                    s_data_i[OffXor +: MaskW], s_data_i[OffReg +: RegW],
                    s_data_i[OffId +: IdW], s_data_i[OffTime +: TimeW]};
      drop_q    <= (count_q == DepthC);
    end
    if (cmd_i.tk_take) begin
      pend_q <= rd_data;
    end
    if (cmd_i.out_status) begin
      m_data_q <= OutDataW'(drop_q);
      m_kind_q <= KindStatus;
      m_last_q <= 1'b1;
    end else if (cmd_i.tk_emit) begin
      m_data_q <= {7'b0, pend_q[EOffOr +: MaskW], pend_q[EOffAnd +: MaskW],
                   pend_q[EOffXor +: MaskW], RegPortW'(pend_q[EOffReg +: RegW]),
                   pend_q[EOffId +: IdW], 1'b0};
      m_kind_q <= KindInject;
      m_last_q <= cmd_i.emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      count_q    <= '0;
      pos_q      <= '0;
      next_due_q <= '1;
      m_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.add_start) begin
        pos_q <= count_q;
      end else if (cmd_i.add_shift) begin
        pos_q <= pos_m1;
      end
      if (cmd_i.add_place) begin
        count_q <= count_q + 1'b1;
        if (pos_q == '0) begin
          next_due_q <= it_time_q;
        end
      end
      if (cmd_i.tk_take) begin
        count_q <= count_q - 1'b1;
        head_q  <= (head_q == LastA) ? '0 : head_q + 1'b1;
      end
      if (cmd_i.tk_stop) begin
        next_due_q <= (count_q != '0) ? rd_time : '1;
      end
      if (cmd_i.out_status || cmd_i.tk_emit) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.full     = drop_q;
  assign sts_o.pos_zero = (pos_q == '0);
  assign sts_o.rd_gt    = (rd_time > it_time_q);
  assign sts_o.rd_due   = (count_q != '0) && (rd_time <= it_time_q);
  assign sts_o.due      = (next_due_q < it_time_q);
  assign sts_o.out_free = out_free;

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_kind_o  = m_kind_q;
  assign m_last_o  = m_last_q;

  `TFIQ_ASSERT(a_count_bound, count_q <= DepthC, "count beyond depth")
  `TFIQ_ASSERT(a_place_count, cmd_i.add_place |=> count_q == $past(count_q) + 1'b1, "insert lost")
  `TFIQ_ASSERT(a_take_count, cmd_i.tk_take |=> count_q == $past(count_q) - 1'b1, "drain lost")

endmodule

// ===== rtl/timed_fault_injection_queue_core.sv =====
// Time-ordered fault table held in one RAM used as a ring buffer. An add request
// (tuser 0) inserts the fault after all entries of equal or earlier time and returns
// one status result; each entry with a later time is moved up one slot through
// the single read and single write port. A full table drops the fault and reports
// status 1. A tick request (tuser 1) whose time is strictly above the earliest due
// time removes every entry at or below that time and emits one injection result per
// entry, tlast on the final one, each entry read through the registered RAM read and
// held back while the output register is full; a tick that is not due finishes with
// no result. One request is worked on at a time; results wait in an output register.
module timed_fault_injection_queue_core #(
  parameter int QUEUE_DEPTH    = tfiq_pkg::DefaultDepth,
  parameter int REG_INDEX_BITS = tfiq_pkg::DefaultRegBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // time_ps, fault_id, reg_index, xor_mask, and_mask, or_mask
  input  logic [tfiq_pkg::InDataW-1:0]  s_axis_tdata,
  // req_type
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status, out_fault_id, out_reg_index, out_xor_mask, out_and_mask, out_or_mask
  output logic [tfiq_pkg::OutDataW-1:0] m_axis_tdata,
  // kind
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast
);
  import tfiq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tfiq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_req_i  (s_axis_tuser),
    .s_ready_o(s_axis_tready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  tfiq_dpath #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .REG_INDEX_BITS(REG_INDEX_BITS)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_data_i (s_axis_tdata),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .m_data_o (m_axis_tdata),
    .m_kind_o (m_axis_tuser),
    .m_last_o (m_axis_tlast),
    .cmd_i    (cmd),
    .sts_o    (sts)
  );

endmodule
